// ===== design/apt_pkg.sv =====
// Shared types and constants for the altitude PID thrust controller.
package apt_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TARGET_HEIGHT = 3'd0;
  localparam logic [2:0] REG_GAIN_P        = 3'd1;
  localparam logic [2:0] REG_GAIN_I        = 3'd2;
  localparam logic [2:0] REG_GAIN_D        = 3'd3;
  localparam logic [2:0] REG_GRAVITY       = 3'd4;
  localparam logic [2:0] REG_MAX_THRUST    = 3'd5;
  localparam logic [2:0] REG_BODY_MASS     = 3'd6;

  // Saturation limit of one gain term magnitude, 2^40.
  localparam logic [40:0] TERM_LIM = 41'h100_0000_0000;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    OP_P,
    OP_D,
    OP_ILO,
    OP_IHI,
    OP_T
  } op_sel_t;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic    take_input;
    logic    prep;
    logic    mul_load;
    op_sel_t mul_sel;
    logic    acc_prod;
    logic    lo_load;
    logic    mag_load;
    logic    acc_mag;
    logic    s_load;
    logic    finish;
  } ctrl_t;

endpackage

// ===== design/apt_mul.sv =====
// Shared 32 by 32 unsigned multiplier with registered operands and product.
module apt_mul
  import apt_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        tag,
  output logic [63:0] prod,
  output logic        prod_tag
);

  logic [31:0] a_r;
  logic [31:0] b_r;
  logic        tag_r;

  // Operands are captured on a request and held until the next one.
  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= a;
      b_r   <= b;
      tag_r <= tag;
    end
  end

  // The product of the held operands is registered, so it follows them in the next cycle.
  always_ff @(posedge clk) begin
    prod     <= 64'(a_r) * 64'(b_r);
    prod_tag <= tag_r;
  end

endmodule

// ===== design/apt_seq.sv =====
// Sequencer that steps one altitude sample through the shared multiplier.
module apt_seq
  import apt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_free,
  output ctrl_t ctrl
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_P    = 12'b0000_0000_0010,
    S_D    = 12'b0000_0000_0100,
    S_IL   = 12'b0000_0000_1000,
    S_IH   = 12'b0000_0001_0000,
    S_W1   = 12'b0000_0010_0000,
    S_W2   = 12'b0000_0100_0000,
    S_AI   = 12'b0000_1000_0000,
    S_SS   = 12'b0001_0000_0000,
    S_T    = 12'b0010_0000_0000,
    S_W3   = 12'b0100_0000_0000,
    S_F    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes for each step.
  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.mul_sel = OP_P;
    unique case (state)
      S_IDLE: begin
        ctrl.take_input = 1'b1;
        if (in_valid) begin
          state_next = S_P;
        end
      end
      S_P: begin
        ctrl.prep     = 1'b1;
        ctrl.mul_load = 1'b1;
        ctrl.mul_sel  = OP_P;
        state_next    = S_D;
      end
      S_D: begin
        ctrl.mul_load = 1'b1;
        ctrl.mul_sel  = OP_D;
        state_next    = S_IL;
      end
      S_IL: begin
        ctrl.mul_load = 1'b1;
        ctrl.mul_sel  = OP_ILO;
        ctrl.acc_prod = 1'b1;
        state_next    = S_IH;
      end
      S_IH: begin
        ctrl.mul_load = 1'b1;
        ctrl.mul_sel  = OP_IHI;
        ctrl.acc_prod = 1'b1;
        state_next    = S_W1;
      end
      S_W1: begin
        ctrl.lo_load = 1'b1;
        state_next   = S_W2;
      end
      S_W2: begin
        ctrl.mag_load = 1'b1;
        state_next    = S_AI;
      end
      S_AI: begin
        ctrl.acc_mag = 1'b1;
        state_next   = S_SS;
      end
      S_SS: begin
        ctrl.s_load = 1'b1;
        state_next  = S_T;
      end
      S_T: begin
        ctrl.mul_load = 1'b1;
        ctrl.mul_sel  = OP_T;
        state_next    = S_W3;
      end
      S_W3: begin
        state_next = S_F;
      end
      S_F: begin
        if (out_free) begin
          ctrl.finish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/altitude_pid_thrust_top.sv =====
// Top level of the altitude PID thrust controller with anti-windup.
//
// Usage: configuration registers are written over cfg_we / cfg_index / cfg_data
// while the block is idle; each write takes effect at once. Altitude samples
// arrive on the in_valid / in_ready channel, one request per control tick, and
// each produces exactly one result on the out_valid / out_ready channel.
// The single shared 32x32 multiplier computes the five products (P term,
// D term, two halves of the I term, and mass times acceleration) in sequence,
// each through registered operands and a registered product, so a new sample
// is taken only once the last one has finished.
// in_ready is high only while no sample is in flight.
// The result sits in an output register; if the receiver stalls, the block
// holds its finished sample and accepts no new sample until the output
// register frees up.
// Reset (synchronous, active high) clears the config registers, the integrator,
// the previous error and out_valid, leaving the block idle with no result pending.
module altitude_pid_thrust_top
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int SUM_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] measured_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] motor_thrust,
  output logic        clamped_high,
  output logic        clamped_low
);

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  ctrl_t ctrl;
  logic  out_free;

  logic signed [31:0] target_height;
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [30:0]        gravity_per_tick;
  logic [31:0]        max_thrust;
  logic [31:0]        body_mass;

  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [31:0]          last_error;

  logic signed [31:0]          err_r;
  logic signed [SUM_WIDTH-1:0] sum_new_r;
  logic signed [32:0]          deriv_r;
  logic signed [42:0]          acc;
  logic [63:0]                 lo_r;
  logic [63:0]                 mag_r;
  logic                        mag_neg_r;
  logic signed [33:0]          s_r;

  logic signed [32:0]          err_diff;
  logic signed [31:0]          err_sat;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic signed [32:0]          deriv_next;

  logic signed [31:0] op_gain;
  logic signed [63:0] op_val;
  logic [31:0]        gain_bits;
  logic [63:0]        val_bits;
  logic [31:0]        gain_mag;
  logic [63:0]        val_mag;
  logic               s_pos;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_tag;
  logic [63:0]        prod;
  logic               prod_tag;

  logic [63:0]        term_src;
  logic               term_neg;
  logic [63:0]        term_shift;
  logic [40:0]        term_cap;
  logic signed [42:0] acc_term;
  logic signed [42:0] acc_next;
  logic signed [31:0] acc32;
  logic signed [33:0] s_next;

  logic [63:0] total_full;
  logic        hi;
  logic        lo;
  logic [31:0] total_sel;

  apt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  apt_mul u_mul (
    .clk      (clk),
    .load     (ctrl.mul_load),
    .a        (mul_a),
    .b        (mul_b),
    .tag      (mul_tag),
    .prod     (prod),
    .prod_tag (prod_tag)
  );

  assign in_ready = ctrl.take_input;
  assign out_free = !out_valid || out_ready;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_height    <= '0;
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      gravity_per_tick <= '0;
      max_thrust       <= '0;
      body_mass        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_HEIGHT: target_height    <= cfg_data;
        REG_GAIN_P:        gain_p           <= cfg_data;
        REG_GAIN_I:        gain_i           <= cfg_data;
        REG_GAIN_D:        gain_d           <= cfg_data;
        REG_GRAVITY:       gravity_per_tick <= cfg_data[30:0];
        REG_MAX_THRUST:    max_thrust       <= cfg_data;
        REG_BODY_MASS:     body_mass        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturated error, integrator update and derivative.
  always_comb begin
    err_diff = 33'(target_height) - 33'(measured_height);
    if (err_diff[32] != err_diff[31]) begin
      err_sat = err_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_sat = err_diff[31:0];
    end
    sum_wide = (SUM_WIDTH+1)'(error_sum) + (SUM_WIDTH+1)'(err_r);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
    deriv_next = 33'(err_r) - 33'(last_error);
  end

  // Multiplier operands: magnitudes of gain and value with the product sign as tag, or body mass and positive command.
  always_comb begin
    case (ctrl.mul_sel)
      OP_P: begin
        op_gain = gain_p;
        op_val  = 64'(err_r);
      end
      OP_D: begin
        op_gain = gain_d;
        op_val  = 64'(deriv_r);
      end
      default: begin
        op_gain = gain_i;
        op_val  = 64'(sum_new_r);
      end
    endcase
    gain_bits = op_gain;
    val_bits  = op_val;
    gain_mag  = gain_bits[31] ? (32'd0 - gain_bits) : gain_bits;
    val_mag   = val_bits[63] ? (64'd0 - val_bits) : val_bits;
    s_pos     = !s_r[33] && (s_r != '0);
    if (ctrl.mul_sel == OP_T) begin
      mul_a   = body_mass;
      mul_b   = s_pos ? s_r[31:0] : 32'd0;
      mul_tag = 1'b0;
    end else begin
      mul_a   = gain_mag;
      mul_b   = (ctrl.mul_sel == OP_IHI) ? val_mag[63:32] : val_mag[31:0];
      mul_tag = gain_bits[31] ^ val_bits[63];
    end
  end

  // Gain term: drop the fraction, saturate the magnitude, then add with its sign.
  always_comb begin
    term_src   = ctrl.acc_mag ? mag_r : prod;
    term_neg   = ctrl.acc_mag ? mag_neg_r : prod_tag;
    term_shift = term_src >> FRAC_BITS;
    term_cap   = (term_shift > 64'(TERM_LIM)) ? TERM_LIM : term_shift[40:0];
    acc_term   = $signed({2'b00, term_cap});
    acc_next   = term_neg ? (acc - acc_term) : (acc + acc_term);
  end

  // Command saturation and gravity offset.
  always_comb begin
    if ((acc[42:31] != '0) && (acc[42:31] != '1)) begin
      acc32 = acc[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      acc32 = acc[31:0];
    end
    s_next = $signed({3'b000, gravity_per_tick}) + 34'(acc32);
  end

  // Thrust clamp.
  always_comb begin
    total_full = prod >> FRAC_BITS;
    hi         = total_full > {32'd0, max_thrust};
    lo         = s_r[33] && (body_mass != '0);
    total_sel  = hi ? max_thrust : total_full[31:0];
  end

  // Working registers of one sample.
  always_ff @(posedge clk) begin
    if (ctrl.take_input && in_valid) begin
      err_r <= err_sat;
    end
    if (ctrl.prep) begin
      sum_new_r <= sum_next;
      deriv_r   <= deriv_next;
    end
    if (ctrl.prep) begin
      acc <= '0;
    end else if (ctrl.acc_prod || ctrl.acc_mag) begin
      acc <= acc_next;
    end
    if (ctrl.lo_load) begin
      lo_r <= prod;
    end
    if (ctrl.mag_load) begin
      mag_r     <= {lo_r[63:32] + prod[31:0], lo_r[31:0]};
      mag_neg_r <= prod_tag;
    end
    if (ctrl.s_load) begin
      s_r <= s_next;
    end
  end

  // Controller state: integrator with anti-windup and previous error.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (ctrl.finish) begin
      if (!hi) begin
        error_sum <= sum_new_r;
      end
      last_error <= err_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      motor_thrust <= total_sel[31:2];
      clamped_high <= hi;
      clamped_low  <= lo;
    end
  end

endmodule
